/* src/vfa_pkg.sv */
// Shared types, constants and helpers for the vortex column acceleration block.
// No dependencies; used by the channel interfaces, the divider and the top level.
package vfa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int CW        = 32;             // coordinate and gain width
  localparam int RW        = 31;             // radius and height width
  localparam int DW        = CW + 1;         // exact difference width
  localparam int CFG_IW    = 4;              // register index width

  // Q constants, round(c * ONE)
  localparam int Q10  = ((10  << FRAC_BITS) + 50) / 100;
  localparam int Q105 = ((105 << FRAC_BITS) + 50) / 100;
  localparam int Q18  = ((18  << FRAC_BITS) + 50) / 100;
  localparam int Q82  = ((82  << FRAC_BITS) + 50) / 100;
  localparam int Q45  = ((45  << FRAC_BITS) + 50) / 100;
  localparam int Q55  = ((55  << FRAC_BITS) + 50) / 100;

  // exact reciprocal multiply for floor(v/3) and floor(v/11) over the used range
  localparam int     D3_S  = FRAC_BITS + 3;
  localparam longint D3_K  = ((longint'(1) << D3_S) + 2) / 3;
  localparam int     D11_S = FRAC_BITS + 8;
  localparam longint D11_K = ((longint'(1) << D11_S) + 10) / 11;

  // square root unit
  localparam int SQ_N = 32;                  // result bits, one per stage
  localparam int SQW  = 2 * SQ_N;            // radicand width

  // divider unit
  localparam int DIV_NW  = DW + FRAC_BITS;   // dividend width
  localparam int DIV_DW  = 32;               // divisor width
  localparam int DIV_QW  = FRAC_BITS + 2;    // quotient width
  localparam int DIV_LAT = DIV_QW + 1;

  // datapath widths
  localparam int TW = FRAC_BITS + 1;         // clamped smoothstep argument
  localparam int SW = FRAC_BITS + 2;         // unit range terms
  localparam int UW = FRAC_BITS + 2;         // signed unit vector
  localparam int YW = DIV_QW + 1;            // signed normalized height
  localparam int KW = CW + 2;                // scaled gains

  typedef logic signed [63:0] wide_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_CENTER_X      = 4'd0,
    REG_CENTER_Y      = 4'd1,
    REG_CENTER_Z      = 4'd2,
    REG_COLUMN_RADIUS = 4'd3,
    REG_COLUMN_HEIGHT = 4'd4,
    REG_INWARD_GAIN   = 4'd5,
    REG_SWIRL_GAIN    = 4'd6,
    REG_LIFT_GAIN     = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DIV_NW-1:0] n;
    logic [DIV_DW-1:0] d;
  } div_in_t;

  typedef struct packed {
    logic [DIV_QW-1:0] q;
    logic              ovf;
  } div_out_t;

  // Q product rounding, halves away from zero
  function automatic wide_t rnd_q(input wide_t p);
    logic        neg;
    logic [63:0] m;
    neg = p[63];
    m   = neg ? 64'(-p) : 64'(p);
    m   = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -wide_t'(m) : wide_t'(m);
  endfunction

  function automatic logic signed [CW-1:0] sat32(input wide_t v);
    if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return v[CW-1:0];
  endfunction

endpackage

/* src/vfa_if.sv */
// Valid/ready channels for sample points and accelerations.
// Depends on vfa_pkg for field widths.
interface vfa_pos_if;
  logic                          valid;
  logic                          ready;
  logic signed [vfa_pkg::CW-1:0] pos_x;
  logic signed [vfa_pkg::CW-1:0] pos_y;
  logic signed [vfa_pkg::CW-1:0] pos_z;
  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface vfa_acc_if;
  logic                          valid;
  logic                          ready;
  logic signed [vfa_pkg::CW-1:0] acc_x;
  logic signed [vfa_pkg::CW-1:0] acc_y;
  logic signed [vfa_pkg::CW-1:0] acc_z;
  modport source (output valid, output acc_x, output acc_y, output acc_z, input ready);
  modport sink   (input valid, input acc_x, input acc_y, input acc_z, output ready);
endinterface

/* src/vfa_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on vfa_pkg for widths and the port structs.
module vfa_div (
  input  logic              clk,
  input  logic              en,
  input  vfa_pkg::div_in_t  din,
  output vfa_pkg::div_out_t dout
);
  import vfa_pkg::*;

  localparam int XW = DIV_DW + DIV_QW;

  logic [DIV_NW-1:0] rem [DIV_LAT];
  logic [DIV_DW-1:0] dvs [DIV_LAT];
  logic [DIV_QW-1:0] quo [DIV_LAT];
  logic [DIV_QW:0]   ovf;
  logic [XW-1:0]     trial [DIV_QW];
  logic [DIV_QW-1:0] ge;

  always_comb begin
    for (int k = 0; k < DIV_QW; k++) begin
      trial[k] = XW'(dvs[k]) << (DIV_QW - 1 - k);
      ge[k]    = XW'(rem[k]) >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= din.n;
      dvs[0] <= din.d;
      quo[0] <= '0;
      ovf[0] <= XW'(din.n) >= {din.d, {DIV_QW{1'b0}}};
      for (int k = 0; k < DIV_QW; k++) begin
        rem[k+1] <= ge[k] ? rem[k] - DIV_NW'(trial[k]) : rem[k];
        quo[k+1] <= ge[k] ? quo[k] | (DIV_QW'(1) << (DIV_QW - 1 - k)) : quo[k];
        dvs[k+1] <= dvs[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  assign dout.q   = quo[DIV_QW];
  assign dout.ovf = ovf[DIV_QW];

endmodule

/* src/vortex_field_acceleration.sv */
// Vortex column acceleration field, top level.
// Each point transaction yields an acceleration transaction; one
// transaction per cycle sustained. Depth is set by the 32-stage square root and
// the 19-stage dividers (one result bit per stage). Whole pipe holds on a stall.
// Reset (rst, synchronous) clears the pipe valid bits and restores register defaults.
// Depends on vfa_pkg, vfa_if and vfa_div.
module vortex_field_acceleration (
  input  logic                      clk,
  input  logic                      rst,
  vfa_pos_if.sink                   points,
  vfa_acc_if.source                 accel,
  input  logic                      cfg_wen,
  input  logic [vfa_pkg::CFG_IW-1:0] cfg_index,
  input  logic [vfa_pkg::CW-1:0]    cfg_data
);
  import vfa_pkg::*;

  // stage map: P1, P2, P3 (= root stage 0), root 1..32, divider, M1..M15
  localparam int ST_M1 = 3 + SQ_N + DIV_LAT;
  localparam int ST_M2 = ST_M1 + 1;
  localparam int LAT   = ST_M1 + 15;

  // ---------------- configuration registers ----------------
  logic signed [CW-1:0] center_x, center_y, center_z;
  logic        [RW-1:0] column_radius, column_height;
  logic signed [CW-1:0] inward_gain, swirl_gain, lift_gain;
  logic        [RW-1:0] radius_eff, height_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      column_radius <= RW'(ONE);
      column_height <= RW'(ONE);
      inward_gain   <= '0;
      swirl_gain    <= '0;
      lift_gain     <= '0;
    end else if (cfg_wen) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:      center_x      <= cfg_data;
        REG_CENTER_Y:      center_y      <= cfg_data;
        REG_CENTER_Z:      center_z      <= cfg_data;
        REG_COLUMN_RADIUS: column_radius <= cfg_data[RW-1:0];
        REG_COLUMN_HEIGHT: column_height <= cfg_data[RW-1:0];
        REG_INWARD_GAIN:   inward_gain   <= cfg_data;
        REG_SWIRL_GAIN:    swirl_gain    <= cfg_data;
        REG_LIFT_GAIN:     lift_gain     <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // radius/height<1.0 act as 1.0; user keeps config static while items fly, unchecked
  assign radius_eff = (column_radius < RW'(ONE)) ? RW'(ONE) : column_radius;
  assign height_eff = (column_height < RW'(ONE)) ? RW'(ONE) : column_height;

  // ---------------- flow control ----------------
  // Every stage advances together; the last stage is the output register.
  logic           en;
  logic [LAT-1:0] vpipe;

  assign en           = !vpipe[LAT-1] || accel.ready;
  assign points.ready = en;
  assign accel.valid  = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], points.valid};
    end
  end

  // ---------------- P1: offsets from the column base ----------------
  logic signed [DW-1:0] p1_dx, p1_dy, p1_dz;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_dx <= DW'(points.pos_x) - DW'(center_x);
      p1_dy <= DW'(points.pos_y) - DW'(center_y);
      p1_dz <= DW'(points.pos_z) - DW'(center_z);
    end
  end

  // ---------------- P2: magnitudes, squares, box test ----------------
  logic [DW-1:0]  adx_c, ady_c, adz_c;
  logic [DW-1:0]  p2_adx, p2_ady, p2_adz;
  logic           p2_sx, p2_sy, p2_sz, p2_box;
  logic [SQW-1:0] p2_sqx, p2_sqz, p2_rsq;

  assign adx_c = p1_dx[DW-1] ? DW'(-p1_dx) : DW'(p1_dx);
  assign ady_c = p1_dy[DW-1] ? DW'(-p1_dy) : DW'(p1_dy);
  assign adz_c = p1_dz[DW-1] ? DW'(-p1_dz) : DW'(p1_dz);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_adx <= adx_c;
      p2_ady <= ady_c;
      p2_adz <= adz_c;
      p2_sx  <= p1_dx[DW-1];
      p2_sy  <= p1_dy[DW-1];
      p2_sz  <= p1_dz[DW-1];
      p2_box <= (adx_c > DW'(radius_eff)) || (adz_c > DW'(radius_eff));
      // inside the box both magnitudes fit 31 bits
      p2_sqx <= SQW'(adx_c[CW-1:0]) * SQW'(adx_c[CW-1:0]);
      p2_sqz <= SQW'(adz_c[CW-1:0]) * SQW'(adz_c[CW-1:0]);
      p2_rsq <= SQW'(radius_eff) * SQW'(radius_eff);
    end
  end

  // ---------------- P3 + root stages: floor(sqrt(dx^2 + dz^2)) ----------------
  logic [SQW-1:0] sq_rem [SQ_N+1];
  logic [SQW-1:0] sq_res [SQ_N+1];
  logic [DW-1:0]  sq_adx [SQ_N+1];
  logic [DW-1:0]  sq_ady [SQ_N+1];
  logic [DW-1:0]  sq_adz [SQ_N+1];
  logic [SQ_N:0]  sq_sx, sq_sy, sq_sz, sq_out;
  logic [SQW-1:0] sq_bit   [SQ_N];
  logic [SQW-1:0] sq_trial [SQ_N];
  logic [SQ_N-1:0] sq_ge;
  logic [SQW-1:0] hsq_c;

  assign hsq_c = p2_sqx + p2_sqz;

  always_comb begin
    for (int k = 0; k < SQ_N; k++) begin
      sq_bit[k]   = SQW'(1) << (2 * (SQ_N - 1 - k));
      sq_trial[k] = sq_res[k] + sq_bit[k];
      sq_ge[k]    = sq_rem[k] >= sq_trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0] <= hsq_c;
      sq_res[0] <= '0;
      sq_adx[0] <= p2_adx;
      sq_ady[0] <= p2_ady;
      sq_adz[0] <= p2_adz;
      sq_sx[0]  <= p2_sx;
      sq_sy[0]  <= p2_sy;
      sq_sz[0]  <= p2_sz;
      sq_out[0] <= p2_box || (hsq_c > p2_rsq);
      for (int k = 0; k < SQ_N; k++) begin
        sq_rem[k+1] <= sq_ge[k] ? sq_rem[k] - sq_trial[k] : sq_rem[k];
        sq_res[k+1] <= sq_ge[k] ? (sq_res[k] >> 1) + sq_bit[k] : sq_res[k] >> 1;
        sq_adx[k+1] <= sq_adx[k];
        sq_ady[k+1] <= sq_ady[k];
        sq_adz[k+1] <= sq_adz[k];
        sq_sx[k+1]  <= sq_sx[k];
        sq_sy[k+1]  <= sq_sy[k];
        sq_sz[k+1]  <= sq_sz[k];
        sq_out[k+1] <= sq_out[k];
      end
    end
  end

  // ---------------- dividers: y, r, |ux|, |uz| ----------------
  logic [SQ_N-1:0] h_c;
  div_in_t  din_y, din_r, din_ux, din_uz;
  div_out_t dout_y, dout_r, dout_ux, dout_uz;
  logic [DIV_LAT-1:0] dv_sx, dv_sy, dv_sz, dv_axis, dv_out;

  assign h_c = sq_res[SQ_N][SQ_N-1:0];

  assign din_y.n  = {sq_ady[SQ_N], {FRAC_BITS{1'b0}}};
  assign din_y.d  = DIV_DW'(height_eff);
  assign din_r.n  = {1'b0, h_c, {FRAC_BITS{1'b0}}};
  assign din_r.d  = DIV_DW'(radius_eff);
  assign din_ux.n = {sq_adx[SQ_N], {FRAC_BITS{1'b0}}};
  assign din_ux.d = h_c;
  assign din_uz.n = {sq_adz[SQ_N], {FRAC_BITS{1'b0}}};
  assign din_uz.d = h_c;

  vfa_div u_div_y  (.clk(clk), .en(en), .din(din_y),  .dout(dout_y));
  vfa_div u_div_r  (.clk(clk), .en(en), .din(din_r),  .dout(dout_r));
  vfa_div u_div_ux (.clk(clk), .en(en), .din(din_ux), .dout(dout_ux));
  vfa_div u_div_uz (.clk(clk), .en(en), .din(din_uz), .dout(dout_uz));

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sx   <= {dv_sx[DIV_LAT-2:0],   sq_sx[SQ_N]};
      dv_sy   <= {dv_sy[DIV_LAT-2:0],   sq_sy[SQ_N]};
      dv_sz   <= {dv_sz[DIV_LAT-2:0],   sq_sz[SQ_N]};
      dv_axis <= {dv_axis[DIV_LAT-2:0], h_c == '0};
      dv_out  <= {dv_out[DIV_LAT-2:0],  sq_out[SQ_N]};
    end
  end

  // ---------------- M1: signs, range test, smoothstep arguments ----------------
  logic signed [YW-1:0] y_c;
  longint               y25_c, w_c, w50_c;
  logic                 zero_c;
  logic        [TW-1:0] t1_c;
  logic signed [UW-1:0] ux_c, uz_c;

  always_comb begin
    y_c    = dv_sy[DIV_LAT-1] ? -$signed(YW'(dout_y.q)) : $signed(YW'(dout_y.q));
    zero_c = dv_out[DIV_LAT-1] || dout_y.ovf ||
             (int'(y_c) < -Q10) || (int'(y_c) > Q105);
    y25_c  = longint'(y_c) * 25;
    w_c    = longint'(ONE) - longint'(y_c);
    w50_c  = w_c * 50;
    t1_c   = (dout_r.q >= DIV_QW'(ONE)) ? '0 : TW'(ONE) - TW'(dout_r.q);
    // inward direction points against the offset; on the axis it is +x
    if (dv_axis[DIV_LAT-1]) begin
      ux_c = UW'(ONE);
      uz_c = '0;
    end else begin
      ux_c = dv_sx[DIV_LAT-1] ? $signed(UW'(dout_ux.q)) : -$signed(UW'(dout_ux.q));
      uz_c = dv_sz[DIV_LAT-1] ? $signed(UW'(dout_uz.q)) : -$signed(UW'(dout_uz.q));
    end
  end

  logic [TW-1:0]          m1_t1;
  logic [FRAC_BITS+1:0]   m1_v2;
  logic [FRAC_BITS+3:0]   m1_v3;
  logic                   m1_t2_zero, m1_t2_one, m1_t3_zero, m1_t3_one;
  logic signed [UW-1:0]   ux_p [13];
  logic signed [UW-1:0]   uz_p [13];
  logic [13:0]            zero_p;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_t1      <= t1_c;
      m1_v2      <= (FRAC_BITS + 2)'(y25_c);
      m1_t2_zero <= y_c <= 0;
      m1_t2_one  <= y25_c >= longint'(3 * ONE);
      m1_v3      <= (FRAC_BITS + 4)'(w50_c);
      m1_t3_zero <= w_c <= 0;
      m1_t3_one  <= w50_c >= longint'(11 * ONE);
      ux_p[0]    <= ux_c;
      uz_p[0]    <= uz_c;
      for (int k = 1; k < 13; k++) begin
        ux_p[k] <= ux_p[k-1];
        uz_p[k] <= uz_p[k-1];
      end
      zero_p <= {zero_p[12:0], zero_c};
    end
  end

  // ---------------- M2: divide by 3 and 11 via reciprocals, clamp ----------------
  logic [63:0]   pr2_c, pr3_c;
  logic [TW-1:0] m2_t [3];

  assign pr2_c = 64'(m1_v2) * 64'(D3_K);
  assign pr3_c = 64'(m1_v3) * 64'(D11_K);

  always_ff @(posedge clk) begin
    if (en) begin
      m2_t[0] <= m1_t1;
      m2_t[1] <= m1_t2_zero ? '0 : (m1_t2_one ? TW'(ONE) : TW'(pr2_c >> D3_S));
      m2_t[2] <= m1_t3_zero ? '0 : (m1_t3_one ? TW'(ONE) : TW'(pr3_c >> D11_S));
    end
  end

  // ---------------- M3..M5: three smoothsteps ----------------
  wide_t         m3_p [3];
  logic [TW-1:0] m3_t [3];
  wide_t         m4_p [3];
  logic [SW-1:0] m5_s [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m3_p[i] <= wide_t'(m2_t[i]) * wide_t'(m2_t[i]);
        m3_t[i] <= m2_t[i];
        m4_p[i] <= rnd_q(m3_p[i]) * (wide_t'(3 * ONE) - (wide_t'(m3_t[i]) <<< 1));
        m5_s[i] <= SW'(rnd_q(m4_p[i]));
      end
    end
  end

  // ---------------- M6..M13: radial, column, swirl and gains ----------------
  wide_t                m6_prad, m6_pcol;
  logic [SW-1:0]        m7_radial, m7_column;
  wide_t                m8_psw1, m8_pki, m8_plift;
  logic [SW-1:0]        m8_column;
  logic [SW-1:0]        m9_a, m9_column;
  logic signed [KW-1:0] ki_p [5];            // M9..M13
  logic signed [CW-1:0] lift_p [6];          // M9..M14
  wide_t                m10_psw;
  logic [SW-1:0]        m11_swirl;
  wide_t                m12_pks;
  logic signed [KW-1:0] m13_ks;

  always_ff @(posedge clk) begin
    if (en) begin
      m6_prad   <= wide_t'(Q82) * wide_t'(m5_s[0]);
      m6_pcol   <= wide_t'(m5_s[1]) * wide_t'(m5_s[2]);
      m7_radial <= SW'(wide_t'(Q18) + rnd_q(m6_prad));
      m7_column <= SW'(rnd_q(m6_pcol));
      m8_psw1   <= wide_t'(Q55) * wide_t'(m7_radial);
      m8_pki    <= wide_t'(inward_gain) * wide_t'(m7_radial);
      m8_plift  <= wide_t'(lift_gain) * wide_t'(m7_column);
      m8_column <= m7_column;
      m9_a      <= SW'(wide_t'(Q45) + rnd_q(m8_psw1));
      m9_column <= m8_column;
      ki_p[0]   <= KW'(rnd_q(m8_pki));
      lift_p[0] <= sat32(rnd_q(m8_plift));
      for (int k = 1; k < 5; k++) ki_p[k] <= ki_p[k-1];
      for (int k = 1; k < 6; k++) lift_p[k] <= lift_p[k-1];
      m10_psw   <= wide_t'(m9_column) * wide_t'(m9_a);
      m11_swirl <= SW'(rnd_q(m10_psw));
      m12_pks   <= wide_t'(swirl_gain) * wide_t'(m11_swirl);
      m13_ks    <= KW'(rnd_q(m12_pks));
    end
  end

  // ---------------- M14: project onto inward and tangent ----------------
  wide_t m14_p [4];

  always_ff @(posedge clk) begin
    if (en) begin
      m14_p[0] <= wide_t'(ux_p[12]) * wide_t'(ki_p[4]);
      m14_p[1] <= -wide_t'(uz_p[12]) * wide_t'(m13_ks);
      m14_p[2] <= wide_t'(uz_p[12]) * wide_t'(ki_p[4]);
      m14_p[3] <= wide_t'(ux_p[12]) * wide_t'(m13_ks);
    end
  end

  // ---------------- M15: output register ----------------
  logic signed [CW-1:0] acc_x_r, acc_y_r, acc_z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_x_r <= zero_p[13] ? '0 : sat32(rnd_q(m14_p[0]) + rnd_q(m14_p[1]));
      acc_y_r <= zero_p[13] ? '0 : lift_p[5];
      acc_z_r <= zero_p[13] ? '0 : sat32(rnd_q(m14_p[2]) + rnd_q(m14_p[3]));
    end
  end

  assign accel.acc_x = acc_x_r;
  assign accel.acc_y = acc_y_r;
  assign accel.acc_z = acc_z_r;

  // ---------------- assertions ----------------
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vpipe))
    else $error("pipe moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !accel.valid)
    else $error("result valid right after reset");

  a_eff_floor: assert property (@(posedge clk) disable iff (rst)
    (radius_eff >= RW'(ONE)) && (height_eff >= RW'(ONE)))
    else $error("effective radius or height below one");

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    vpipe[ST_M2] |-> (m2_t[1] <= TW'(ONE)) && (m2_t[2] <= TW'(ONE)))
    else $error("smoothstep argument above one");

endmodule
